/* rtl/stepdrv_pkg.sv */
`default_nettype none

package stepdrv_pkg;

  localparam int unsigned STEP_WIDTH    = 16;
  localparam int unsigned PENDING_WIDTH = 16;
  localparam int unsigned PHASE_WIDTH   = 3;
  localparam int unsigned COIL_WIDTH    = 4;
  localparam int unsigned STATUS_WIDTH  = 3;
  localparam int unsigned SAT_WIDTH     = 34;

  localparam logic signed [SAT_WIDTH-1:0] PendMax =
    SAT_WIDTH'((longint'(1) << (PENDING_WIDTH - 1)) - longint'(1));
  localparam logic signed [SAT_WIDTH-1:0] PendMin =
    SAT_WIDTH'(-(longint'(1) << (PENDING_WIDTH - 1)));

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_MOVE = 1'b1
  } action_e;

  typedef enum logic {
    AXIS_AZ = 1'b0,
    AXIS_EL = 1'b1
  } axis_sel_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STAT_IDLE   = 3'd0,
    STAT_REENG  = 3'd1,
    STAT_STEP   = 3'd2,
    STAT_LIMIT  = 3'd3,
    STAT_OFF    = 3'd4
  } status_e;

  typedef struct packed {
    logic tick;
    logic load;
    logic fwd_clear;
    logic back_clear;
  } axis_ctrl_t;

  typedef struct packed {
    logic [COIL_WIDTH-1:0] coils;
    status_e               status;
  } axis_res_t;

  function automatic logic [COIL_WIDTH-1:0] coil_pattern(logic [PHASE_WIDTH-1:0] phase);
    logic [COIL_WIDTH-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

  function automatic logic signed [PENDING_WIDTH-1:0] sat_count(
    logic signed [STEP_WIDTH-1:0] v
  );
    logic signed [SAT_WIDTH-1:0] ext;
    logic signed [SAT_WIDTH-1:0] res;
    ext = SAT_WIDTH'(v);
    if (ext > PendMax) begin
      res = PendMax;
    end else if (ext < PendMin) begin
      res = PendMin;
    end else begin
      res = ext;
    end
    return res[PENDING_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/stepdrv_if.sv */
`default_nettype none

interface stepdrv_in_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        action;
  logic                                        axis;
  logic signed [stepdrv_pkg::STEP_WIDTH-1:0]   step_count;
  logic                                        right_clear;
  logic                                        left_clear;
  logic                                        up_clear;
  logic                                        down_clear;

  modport source (
    output valid, action, axis, step_count, right_clear, left_clear, up_clear, down_clear,
    input  ready
  );

  modport sink (
    input  valid, action, axis, step_count, right_clear, left_clear, up_clear, down_clear,
    output ready
  );
endinterface

interface stepdrv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [stepdrv_pkg::COIL_WIDTH-1:0]    azimuth_coils;
  logic [stepdrv_pkg::COIL_WIDTH-1:0]    elevation_coils;
  logic [stepdrv_pkg::STATUS_WIDTH-1:0]  azimuth_status;
  logic [stepdrv_pkg::STATUS_WIDTH-1:0]  elevation_status;

  modport source (
    output valid, azimuth_coils, elevation_coils, azimuth_status, elevation_status,
    input  ready
  );

  modport sink (
    input  valid, azimuth_coils, elevation_coils, azimuth_status, elevation_status,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/stepdrv_axis.sv */
`default_nettype none

module stepdrv_axis (
  input  wire                                              clk_i,
  input  wire                                              rst_ni,
  input  wire stepdrv_pkg::axis_ctrl_t                     ctrl_i,
  input  wire logic signed [stepdrv_pkg::PENDING_WIDTH-1:0] load_value_i,
  output stepdrv_pkg::axis_res_t                           res_o
);

  logic [stepdrv_pkg::PHASE_WIDTH-1:0]          phase_q, phase_d;
  logic signed [stepdrv_pkg::PENDING_WIDTH-1:0] pending_q, pending_d;
  logic [stepdrv_pkg::COIL_WIDTH-1:0]           drive_q, drive_d;
  stepdrv_pkg::status_e                         status;

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    drive_d   = drive_q;
    status    = stepdrv_pkg::STAT_IDLE;
    if (ctrl_i.load) begin
      pending_d = load_value_i;
    end else if (ctrl_i.tick) begin
      if (pending_q != '0) begin
        if (drive_q == '0) begin
          drive_d = stepdrv_pkg::coil_pattern(phase_q);
          status  = stepdrv_pkg::STAT_REENG;
        end else if (!pending_q[stepdrv_pkg::PENDING_WIDTH-1]) begin
          if (!ctrl_i.fwd_clear) begin
            pending_d = '0;
            status    = stepdrv_pkg::STAT_LIMIT;
          end else begin
            phase_d   = phase_q + stepdrv_pkg::PHASE_WIDTH'(1);
            pending_d = pending_q - stepdrv_pkg::PENDING_WIDTH'(1);
            drive_d   = stepdrv_pkg::coil_pattern(phase_d);
            status    = stepdrv_pkg::STAT_STEP;
          end
        end else begin
          if (!ctrl_i.back_clear) begin
            pending_d = '0;
            status    = stepdrv_pkg::STAT_LIMIT;
          end else begin
            phase_d   = phase_q - stepdrv_pkg::PHASE_WIDTH'(1);
            pending_d = pending_q + stepdrv_pkg::PENDING_WIDTH'(1);
            drive_d   = stepdrv_pkg::coil_pattern(phase_d);
            status    = stepdrv_pkg::STAT_STEP;
          end
        end
      end else if (drive_q != '0) begin
        drive_d = '0;
        status  = stepdrv_pkg::STAT_OFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      pending_q <= '0;
      drive_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      drive_q   <= drive_d;
    end
  end

  assign res_o.coils  = drive_d;
  assign res_o.status = status;

endmodule

`default_nettype wire

/* rtl/dual_axis_half_step_stepper_driver_top.sv */
`default_nettype none

// Two-axis half-step stepper sequencer. Each input beat is either a move, which loads the
// signed pending half-step count of one axis, or a tick, which advances both axes by at most
// one half step and reports the new coil drive and a status code per axis. One beat is
// accepted every cycle while results are taken; each beat passes an input register and
// then the axis update that loads the result register. A stalled result holds the
// pipeline, and ready drops only while both registers are full.

module dual_axis_half_step_stepper_driver_top (
  input wire            clk_i,
  input wire            rst_ni,
  stepdrv_in_if.sink    in_i,
  stepdrv_out_if.source out_o
);

  logic                                        in_valid_q;
  logic                                        action_q;
  logic                                        axis_q;
  logic signed [stepdrv_pkg::STEP_WIDTH-1:0]   step_q;
  logic                                        right_q, left_q, up_q, down_q;
  logic                                        out_valid_q;
  stepdrv_pkg::axis_res_t                      az_res_q, el_res_q;
  logic                                        advance;
  logic                                        in_ready;
  logic                                        fire;
  logic                                        is_tick;
  logic                                        is_move;
  logic signed [stepdrv_pkg::PENDING_WIDTH-1:0] load_value;
  stepdrv_pkg::axis_ctrl_t                     az_ctrl, el_ctrl;
  stepdrv_pkg::axis_res_t                      az_res, el_res;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !in_valid_q || advance;
  assign fire     = in_valid_q && advance;
  assign is_tick  = fire && (action_q == stepdrv_pkg::ACT_TICK);
  assign is_move  = fire && (action_q == stepdrv_pkg::ACT_MOVE);
  assign load_value = stepdrv_pkg::sat_count(step_q);

  assign az_ctrl.tick       = is_tick;
  assign az_ctrl.load       = is_move && (axis_q == stepdrv_pkg::AXIS_AZ);
  assign az_ctrl.fwd_clear  = right_q;
  assign az_ctrl.back_clear = left_q;
  assign el_ctrl.tick       = is_tick;
  assign el_ctrl.load       = is_move && (axis_q == stepdrv_pkg::AXIS_EL);
  assign el_ctrl.fwd_clear  = up_q;
  assign el_ctrl.back_clear = down_q;

  stepdrv_axis u_az (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (az_ctrl),
    .load_value_i (load_value),
    .res_o        (az_res)
  );

  stepdrv_axis u_el (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (el_ctrl),
    .load_value_i (load_value),
    .res_o        (el_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      action_q <= in_i.action;
      axis_q   <= in_i.axis;
      step_q   <= in_i.step_count;
      right_q  <= in_i.right_clear;
      left_q   <= in_i.left_clear;
      up_q     <= in_i.up_clear;
      down_q   <= in_i.down_clear;
    end
    if (fire) begin
      az_res_q <= az_res;
      el_res_q <= el_res;
    end
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.azimuth_coils    = az_res_q.coils;
  assign out_o.elevation_coils  = el_res_q.coils;
  assign out_o.azimuth_status   = az_res_q.status;
  assign out_o.elevation_status = el_res_q.status;

`ifndef SYNTHESIS
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready)
    else $error("Input ready is low while the result register is free.");

  a_held_beat_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("A held input beat was lost.");

  a_off_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (az_res_q.status == stepdrv_pkg::STAT_OFF) |-> (az_res_q.coils == '0))
    else $error("Azimuth switched off but coils are still driven.");

  a_step_energized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (el_res_q.status == stepdrv_pkg::STAT_STEP)
      |-> ($countones(el_res_q.coils) == 1 || $countones(el_res_q.coils) == 2))
    else $error("Elevation stepped to a coil pattern outside the half-step table.");

  a_move_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_move |=> (az_res_q.status == stepdrv_pkg::STAT_IDLE)
      && (el_res_q.status == stepdrv_pkg::STAT_IDLE))
    else $error("A move beat reported a nonidle status.");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
  import stepdrv_pkg::*;

  typedef struct packed {
    logic [COIL_WIDTH-1:0] az_coils;
    logic [COIL_WIDTH-1:0] el_coils;
    status_e               az_st;
    status_e               el_st;
  } result_t;

  // The clears field is ordered {right, left, up, down}.
  typedef struct packed {
    action_e                      act;
    axis_sel_e                    ax;
    logic signed [STEP_WIDTH-1:0] count;
    logic [3:0]                   clears;
    logic                         typed;
    result_t                      want;
  } row_t;

  localparam int RANDOM_BEATS   = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int NUM_ROWS       = 24;

  localparam longint PEND_HI = (longint'(1) << (PENDING_WIDTH - 1)) - 1;
  localparam longint PEND_LO = -(longint'(1) << (PENDING_WIDTH - 1));

  localparam logic [COIL_WIDTH-1:0] HALF_STEP_COILS [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b1111, 1'b1, '{4'h0, 4'h0, STAT_IDLE, STAT_IDLE}},
    '{ACT_MOVE, AXIS_AZ, 16'sh0002, 4'b0000, 1'b1, '{4'h0, 4'h0, STAT_IDLE, STAT_IDLE}},
    '{ACT_MOVE, AXIS_EL, 16'sh8000, 4'b1111, 1'b1, '{4'h0, 4'h0, STAT_IDLE, STAT_IDLE}},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b1111, 1'b1, '{4'h1, 4'h1, STAT_REENG, STAT_REENG}},
    '{ACT_TICK, AXIS_EL, 16'shFFFF, 4'b1111, 1'b1, '{4'h3, 4'h9, STAT_STEP, STAT_STEP}},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b0110, 1'b1, '{4'h3, 4'h9, STAT_LIMIT, STAT_LIMIT}},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b0000, 1'b1, '{4'h0, 4'h0, STAT_OFF, STAT_OFF}},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b0000, 1'b1, '{4'h0, 4'h0, STAT_IDLE, STAT_IDLE}},
    '{ACT_MOVE, AXIS_AZ, 16'sh7FFF, 4'b1111, 1'b1, '{4'h0, 4'h0, STAT_IDLE, STAT_IDLE}},
    '{ACT_MOVE, AXIS_AZ, 16'shFFFF, 4'b0000, 1'b1, '{4'h0, 4'h0, STAT_IDLE, STAT_IDLE}},
    '{ACT_MOVE, AXIS_EL, 16'sh0001, 4'b0000, 1'b1, '{4'h0, 4'h0, STAT_IDLE, STAT_IDLE}},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b0000, 1'b1, '{4'h3, 4'h9, STAT_REENG, STAT_REENG}},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b0110, 1'b1, '{4'h1, 4'h1, STAT_STEP, STAT_STEP}},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b0000, 1'b1, '{4'h0, 4'h0, STAT_OFF, STAT_OFF}},
    '{ACT_MOVE, AXIS_EL, 16'sh5555, 4'b1010, 1'b0, '0},
    '{ACT_MOVE, AXIS_AZ, 16'shAAAA, 4'b0101, 1'b0, '0},
    '{ACT_TICK, AXIS_EL, 16'sh1234, 4'b1111, 1'b0, '0},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b1111, 1'b0, '0},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b1001, 1'b0, '0},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b1111, 1'b0, '0},
    '{ACT_MOVE, AXIS_AZ, 16'sh8000, 4'b0000, 1'b0, '0},
    '{ACT_MOVE, AXIS_EL, 16'sh7FFF, 4'b0000, 1'b0, '0},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b1111, 1'b0, '0},
    '{ACT_TICK, AXIS_AZ, 16'sh0000, 4'b1111, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  stepdrv_in_if  in_bus ();
  stepdrv_out_if out_bus ();

  dual_axis_half_step_stepper_driver_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  logic [PHASE_WIDTH-1:0]          az_phase, el_phase;
  logic signed [PENDING_WIDTH-1:0] az_pending, el_pending;
  logic [COIL_WIDTH-1:0]           az_drive, el_drive;

  result_t coil_results_q [$];
  logic    cur_typed;
  result_t cur_want;

  int errors;
  int beats_sent;
  int results_taken;
  int moves_seen;
  int ticks_seen;
  int outcome_hits [5];
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic status_e advance_axis(
    inout logic [PHASE_WIDTH-1:0]          ph,
    inout logic signed [PENDING_WIDTH-1:0] pend,
    inout logic [COIL_WIDTH-1:0]           drv,
    input logic                            fwd_ok,
    input logic                            back_ok
  );
    if (pend != 0) begin
      if (drv == 0) begin
        drv = HALF_STEP_COILS[ph];
        return STAT_REENG;
      end
      if (pend > 0) begin
        if (!fwd_ok) begin
          pend = '0;
          return STAT_LIMIT;
        end
        ph = ph + 1'b1;
        pend = PENDING_WIDTH'(pend - 1);
      end else begin
        if (!back_ok) begin
          pend = '0;
          return STAT_LIMIT;
        end
        ph = ph - 1'b1;
        pend = PENDING_WIDTH'(pend + 1);
      end
      drv = HALF_STEP_COILS[ph];
      return STAT_STEP;
    end
    if (drv != 0) begin
      drv = '0;
      return STAT_OFF;
    end
    return STAT_IDLE;
  endfunction

  function automatic result_t predict_coils(input row_t r);
    result_t res;
    longint  v;
    res = '0;
    if (r.act == ACT_MOVE) begin
      v = longint'(r.count);
      if (v > PEND_HI) v = PEND_HI;
      if (v < PEND_LO) v = PEND_LO;
      if (r.ax == AXIS_EL) begin
        el_pending = v[PENDING_WIDTH-1:0];
      end else begin
        az_pending = v[PENDING_WIDTH-1:0];
      end
    end else begin
      res.az_st = advance_axis(az_phase, az_pending, az_drive, r.clears[3], r.clears[2]);
      res.el_st = advance_axis(el_phase, el_pending, el_drive, r.clears[1], r.clears[0]);
    end
    res.az_coils = az_drive;
    res.el_coils = el_drive;
    return res;
  endfunction

  function automatic row_t random_beat();
    row_t r;
    int   pick;
    r = '0;
    r.act = ($urandom_range(0, 3) == 0) ? ACT_MOVE : ACT_TICK;
    r.ax = axis_sel_e'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      r.count = STEP_WIDTH'(int'($urandom_range(0, 40)) - 20);
    end else if (pick < 9) begin
      r.count = STEP_WIDTH'($urandom);
    end else begin
      r.count = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    end
    for (int b = 0; b < 4; b++) begin
      r.clears[b] = ($urandom_range(0, 7) != 0);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_taken, what, got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input row_t r, input bit hold);
    int gap;
    gap = (((beats_sent / 40) % 3) == 1) ? 0 : $urandom_range(0, 15);
    if (hold || gap != 0) begin
      in_bus.valid <= 1'b0;
      do @(negedge clk_i); while (hold && coil_results_q.size() != 0);
      repeat (gap > 0 ? gap - 1 : 0) @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= r.act;
    in_bus.axis        <= r.ax;
    in_bus.step_count  <= r.count;
    in_bus.right_clear <= r.clears[3];
    in_bus.left_clear  <= r.clears[2];
    in_bus.up_clear    <= r.clears[1];
    in_bus.down_clear  <= r.clears[0];
    cur_typed          <= r.typed;
    cur_want           <= r.want;
    do @(posedge clk_i); while (!in_bus.ready);
    beats_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    row_t    seen_in;
    result_t want;
    logic    took_in;
    logic    took_out;
    took_in  = rst_ni && in_bus.valid && in_bus.ready;
    took_out = rst_ni && out_bus.valid && out_bus.ready;
    if (took_in) begin
      seen_in = '0;
      seen_in.act    = action_e'(in_bus.action);
      seen_in.ax     = axis_sel_e'(in_bus.axis);
      seen_in.count  = in_bus.step_count;
      seen_in.clears = {in_bus.right_clear, in_bus.left_clear,
                        in_bus.up_clear, in_bus.down_clear};
      want = predict_coils(seen_in);
      if (seen_in.act == ACT_MOVE) begin
        moves_seen++;
      end else begin
        ticks_seen++;
        outcome_hits[want.az_st]++;
        outcome_hits[want.el_st]++;
      end
      if (cur_typed) want = cur_want;
      coil_results_q.push_back(want);
    end
    if (took_out) begin
      if (coil_results_q.size() == 0) begin
        report_mismatch("unexpected beat, azimuth_coils", out_bus.azimuth_coils, 0);
      end else begin
        want = coil_results_q.pop_front();
        if (out_bus.azimuth_coils !== want.az_coils)
          report_mismatch("azimuth_coils", out_bus.azimuth_coils, want.az_coils);
        if (out_bus.elevation_coils !== want.el_coils)
          report_mismatch("elevation_coils", out_bus.elevation_coils, want.el_coils);
        if (out_bus.azimuth_status !== want.az_st)
          report_mismatch("azimuth_status", out_bus.azimuth_status, want.az_st);
        if (out_bus.elevation_status !== want.el_st)
          report_mismatch("elevation_status", out_bus.elevation_status, want.el_st);
      end
      results_taken++;
    end
    if (took_in || took_out) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", coil_results_q.size());
      $display("dual_axis_half_step_stepper_driver_top regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random and once holds off long enough to back up the input.
  initial begin
    int  stall;
    bit  long_done;
    long_done = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = (((results_taken / 50) % 3) == 2) ? 0 : $urandom_range(0, 15);
      if (!long_done && results_taken >= 120) begin
        stall = LONG_HOLD;
        long_done = 1'b1;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    row_t r;
    errors        = 0;
    beats_sent    = 0;
    results_taken = 0;
    moves_seen    = 0;
    ticks_seen    = 0;
    idle_cycles   = 0;
    foreach (outcome_hits[k]) outcome_hits[k] = 0;
    az_phase   = '0;
    el_phase   = '0;
    az_pending = '0;
    el_pending = '0;
    az_drive   = '0;
    el_drive   = '0;
    cur_typed  = 1'b0;
    cur_want   = '0;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.action      = 1'b0;
    in_bus.axis        = 1'b0;
    in_bus.step_count  = '0;
    in_bus.right_clear = 1'b0;
    in_bus.left_clear  = 1'b0;
    in_bus.up_clear    = 1'b0;
    in_bus.down_clear  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_beat(DIRECTED[i], 1'b0);
    end

    // Halfway through, the sender waits until every outstanding beat has come back.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      r = random_beat();
      send_beat(r, i == RANDOM_BEATS / 2);
    end

    in_bus.valid <= 1'b0;
    while (coil_results_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d beats (%0d moves, %0d ticks), %0d results checked, %0d errors.",
             beats_sent, moves_seen, ticks_seen, results_taken, errors);
    $display("Axis outcomes: idle %0d, re-energized %0d, stepped %0d, limit %0d, off %0d.",
             outcome_hits[STAT_IDLE], outcome_hits[STAT_REENG], outcome_hits[STAT_STEP],
             outcome_hits[STAT_LIMIT], outcome_hits[STAT_OFF]);
    if (errors == 0) begin
      $display("dual_axis_half_step_stepper_driver_top regression: pass");
    end else begin
      $display("dual_axis_half_step_stepper_driver_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
